>>> rtl/b2b_pkg.sv
// b2b_pkg: constants, types and helper functions for the BLAKE2b engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package b2b_pkg;

  localparam int unsigned DefDigestLen = 8;
  localparam int unsigned MaxDigest    = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_INIT,
    ST_MIX,
    ST_FOLD,
    ST_OUT
  } state_t;

  // message word schedule, round r, slot s (16 slots)
  function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] s);
    logic [63:0] row;
    begin
      case (r)
        4'd0, 4'd10: row = 64'hfedcba9876543210;
        4'd1, 4'd11: row = 64'h357b20c16df984ae;
        4'd2:        row = 64'h491763eadf250c8b;
        4'd3:        row = 64'h8f04a562ebcd1397;
        4'd4:        row = 64'hd386cb1efa427509;
        4'd5:        row = 64'h91ef57d438b0a6c2;
        4'd6:        row = 64'hb8293670a4def15c;
        4'd7:        row = 64'ha2684f05931ce7bd;
        4'd8:        row = 64'h5a417d2c803b9ef6;
        4'd9:        row = 64'h0dc3e9bf5167482a;
        default:     row = 64'hfedcba9876543210;
      endcase
      sigma = row[{s, 2'b00} +: 4];
    end
  endfunction

  // indices a,b,c,d of G function g (0..7), packed a in low nibble
  function automatic logic [15:0] mix_index(input logic [2:0] g);
    case (g)
      3'd0: mix_index = 16'hc840;
      3'd1: mix_index = 16'hd951;
      3'd2: mix_index = 16'hea62;
      3'd3: mix_index = 16'hfb73;
      3'd4: mix_index = 16'hfa50;
      3'd5: mix_index = 16'hcb61;
      3'd6: mix_index = 16'hd872;
      default: mix_index = 16'he943;
    endcase
  endfunction

  function automatic logic [63:0] iv(input logic [2:0] i);
    case (i)
      3'd0: iv = 64'h6a09e667f3bcc908;
      3'd1: iv = 64'hbb67ae8584caa73b;
      3'd2: iv = 64'h3c6ef372fe94f82b;
      3'd3: iv = 64'ha54ff53a5f1d36f1;
      3'd4: iv = 64'h510e527fade682d1;
      3'd5: iv = 64'h9b05688c2b3e6c1f;
      3'd6: iv = 64'h1f83d9abfb41bd6b;
      default: iv = 64'h5be0cd19137e2179;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> rtl/b2b_if.sv
// b2b_if: valid/ready channel interfaces for the BLAKE2b engine.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface b2b_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;
  modport source (output valid, data_byte, has_byte, last, input ready);
  modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface

interface b2b_digest_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic        last_word;
  modport source (output valid, digest_word, last_word, input ready);
  modport sink   (input valid, digest_word, last_word, output ready);
endinterface

interface b2b_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] digest_length;
  modport source (output valid, digest_length, input ready);
  modport sink   (input valid, digest_length, output ready);
endinterface
`default_nettype wire

>>> rtl/blake2b_hash_engine.sv
// blake2b_hash_engine: unkeyed BLAKE2b over a byte stream.
// Depends on b2b_pkg and the channel interfaces in b2b_if.sv.
//
// channel    dir  payload
// in_ch      in   data_byte[7:0], has_byte, last
// out_ch     out  digest_word[63:0], last_word
// cfg_ch     in   digest_length[6:0]
//
// A byte that does not start a new block is written to the buffer in IDLE. A byte arriving on a
// full buffer runs one compression through INIT, MIX and FOLD, with MIX run by the single
// shared G half-step unit (one half-G per cycle, 12 rounds x 8 G x 2).
// A last item first zero-pads the buffer in LOAD before its compression; a last
// item whose byte lands on a full buffer runs both compressions back to back.
// Digest words then leave one per cycle as taken.
// Synchronous reset; in_ch is not ready while compressing or emitting.
`timescale 1ns / 1ps
`default_nettype none
module blake2b_hash_engine (
  input  wire logic clk,
  input  wire logic rst,
  b2b_byte_if.sink     in_ch,
  b2b_digest_if.source out_ch,
  b2b_cfg_if.sink      cfg_ch
);

  b2b_pkg::state_t state, state_next;

  logic [6:0]   eff_len;        // clamped digest length 1..64
  logic [63:0]  h [8];
  logic [63:0]  v [16];
  logic [63:0]  cnt_lo, cnt_hi;
  logic [63:0]  mem [16];       // block buffer, undefined until written
  logic [7:0]   fill;           // 0..128
  logic         final_blk;      // current compression is the final one
  logic [7:0]   pend_byte;      // byte waiting for a compression
  logic         pend_has;
  logic         pend_last;
  logic [3:0]   step;           // generic counter for LOAD/INIT/FOLD
  logic [3:0]   round;
  logic [2:0]   gsel;
  logic         half;
  logic [2:0]   oidx;

  // clamp of a written length
  logic [6:0] cfg_len;
  always_comb begin
    if (cfg_ch.digest_length == 7'd0) cfg_len = 7'd1;
    else if (cfg_ch.digest_length > 7'(b2b_pkg::MaxDigest))
      cfg_len = 7'(b2b_pkg::MaxDigest);
    else cfg_len = cfg_ch.digest_length;
  end

  assign cfg_ch.ready = (state == b2b_pkg::ST_IDLE);
  wire cfg_go = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready  = (state == b2b_pkg::ST_IDLE) && !cfg_ch.valid;
  wire in_go  = in_ch.valid && in_ch.ready;

  // shared half-G unit
  logic [15:0] mi;
  logic [3:0]  ia, ib, ic, id;
  logic [3:0]  widx;
  logic [63:0] mword, na, nb, nc, nd, ta, tc;
  always_comb begin
    mi = b2b_pkg::mix_index(gsel);
    ia = mi[3:0];
    ib = mi[7:4];
    ic = mi[11:8];
    id = mi[15:12];
    widx = b2b_pkg::sigma(round, {gsel, half});
    mword = mem[widx];
    ta = v[ia] + v[ib] + mword;
    nd = v[id] ^ ta;
    nd = half ? {nd[15:0], nd[63:16]} : {nd[31:0], nd[63:32]};
    tc = v[ic] + nd;
    nb = v[ib] ^ tc;
    nb = half ? {nb[62:0], nb[63]} : {nb[23:0], nb[63:24]};
    na = ta;
    nc = tc;
  end

  // buffer write address: position of current byte
  logic [7:0]  wfill;
  logic [63:0] lane_mask;
  logic [63:0] cur_word, out_word, tmask;
  logic [6:0]  rem;
  always_comb begin
    wfill = (state == b2b_pkg::ST_IDLE) ? fill : 8'd0;
    cur_word = mem[wfill[6:3]];
    lane_mask = 64'hff << {wfill[2:0], 3'b000};
    rem = eff_len - {1'b0, oidx, 3'b000};
    tmask = (rem < 7'd8) ? ((64'd1 << {rem[2:0], 3'b000}) - 64'd1) : '1;
    out_word = h[oidx] & tmask;
  end
  wire [2:0] last_oidx = 3'((eff_len - 7'd1) >> 3);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      b2b_pkg::ST_IDLE: begin
        if (in_go) begin
          if (in_ch.has_byte && fill[7]) state_next = b2b_pkg::ST_INIT;
          else if (in_ch.last) state_next = b2b_pkg::ST_LOAD;
        end
      end
      b2b_pkg::ST_LOAD: state_next = (step == 4'd15) ? b2b_pkg::ST_INIT : state;
      b2b_pkg::ST_INIT: state_next = (step == 4'd15) ? b2b_pkg::ST_MIX : state;
      b2b_pkg::ST_MIX:
        if (round == 4'd11 && gsel == 3'd7 && half) state_next = b2b_pkg::ST_FOLD;
      b2b_pkg::ST_FOLD:
        if (step == 4'd7) begin
          if (final_blk) state_next = b2b_pkg::ST_OUT;
          else if (pend_last) state_next = b2b_pkg::ST_LOAD;
          else state_next = b2b_pkg::ST_IDLE;
        end
      b2b_pkg::ST_OUT:
        if (out_ch.ready && oidx == last_oidx) state_next = b2b_pkg::ST_IDLE;
      default: state_next = b2b_pkg::ST_IDLE;
    endcase
  end

  assign out_ch.valid       = (state == b2b_pkg::ST_OUT);
  assign out_ch.digest_word = out_word;
  assign out_ch.last_word   = (oidx == last_oidx);

  always_ff @(posedge clk) begin
    if (rst) state <= b2b_pkg::ST_IDLE;
    else state <= state_next;
  end

  // block buffer: byte writes and zero padding
  always_ff @(posedge clk) begin
    if (state == b2b_pkg::ST_IDLE && in_go && in_ch.has_byte && !fill[7]) begin
      mem[fill[6:3]] <= (((fill[2:0] == 3'd0) ? 64'd0 : cur_word) & ~lane_mask) |
                        ({56'd0, in_ch.data_byte} << {fill[2:0], 3'b000});
    end else if (state == b2b_pkg::ST_LOAD && {1'b0, step} >= 5'((fill + 8'd7) >> 3)) begin
      mem[step] <= 64'd0;
    end else if (state == b2b_pkg::ST_FOLD && step == 4'd7 && !final_blk && pend_has) begin
      mem[0] <= {56'd0, pend_byte};
    end
  end

  // control and data path registers
  always_ff @(posedge clk) begin
    if (rst || cfg_go) begin
      eff_len <= rst ? 7'(b2b_pkg::DefDigestLen) : cfg_len;
      for (int i = 1; i < 8; i++) h[i] <= b2b_pkg::iv(3'(i));
      h[0] <= b2b_pkg::iv(3'd0) ^ 64'h01010000 ^
              {57'd0, rst ? 7'(b2b_pkg::DefDigestLen) : cfg_len};
      cnt_lo <= '0;
      cnt_hi <= '0;
      fill <= '0;
      step <= '0;
      round <= '0;
      gsel <= '0;
      half <= 1'b0;
      oidx <= '0;
      final_blk <= 1'b0;
    end else begin
      case (state)
        b2b_pkg::ST_IDLE: begin
          step <= '0;
          round <= '0;
          gsel <= '0;
          half <= 1'b0;
          oidx <= '0;
          if (in_go) begin
            pend_byte <= in_ch.data_byte;
            pend_has  <= in_ch.has_byte;
            pend_last <= in_ch.last;
            if (in_ch.has_byte && fill[7]) begin
              final_blk <= 1'b0;
              {cnt_hi, cnt_lo} <= {cnt_hi, cnt_lo} + 128'd128;
            end else begin
              if (in_ch.has_byte) fill <= fill + 8'd1;
              if (in_ch.last) begin
                final_blk <= 1'b1;
                {cnt_hi, cnt_lo} <= {cnt_hi, cnt_lo} + {120'd0, fill} +
                                    {127'd0, in_ch.has_byte};
              end
            end
          end
        end
        b2b_pkg::ST_LOAD: step <= step + 4'd1;
        b2b_pkg::ST_INIT: begin
          step <= step + 4'd1;
          if (!step[3]) v[step] <= h[step[2:0]];
          else begin
            case (step[2:0])
              3'd4: v[step] <= b2b_pkg::iv(step[2:0]) ^ cnt_lo;
              3'd5: v[step] <= b2b_pkg::iv(step[2:0]) ^ cnt_hi;
              3'd6: v[step] <= final_blk ? ~b2b_pkg::iv(step[2:0])
                                         : b2b_pkg::iv(step[2:0]);
              default: v[step] <= b2b_pkg::iv(step[2:0]);
            endcase
          end
        end
        b2b_pkg::ST_MIX: begin
          v[ia] <= na;
          v[ib] <= nb;
          v[ic] <= nc;
          v[id] <= nd;
          half <= ~half;
          step <= '0;
          if (half) begin
            gsel <= gsel + 3'd1;
            if (gsel == 3'd7) round <= round + 4'd1;
          end
        end
        b2b_pkg::ST_FOLD: begin
          step <= (step == 4'd7) ? 4'd0 : step + 4'd1;
          h[step[2:0]] <= h[step[2:0]] ^ v[step[2:0]] ^ v[{1'b1, step[2:0]}];
          if (step == 4'd7 && !final_blk) begin
            fill <= pend_has ? 8'd1 : 8'd0;
            round <= '0;
            if (pend_last) begin
              // chained finish: the held byte is counted, then LOAD with final flag
              final_blk <= 1'b1;
              {cnt_hi, cnt_lo} <= {cnt_hi, cnt_lo} + {127'd0, pend_has};
            end
          end
        end
        b2b_pkg::ST_OUT: begin
          if (out_ch.ready) begin
            oidx <= oidx + 3'd1;
            if (oidx == last_oidx) begin
              for (int i = 1; i < 8; i++) h[i] <= b2b_pkg::iv(3'(i));
              h[0] <= b2b_pkg::iv(3'd0) ^ 64'h01010000 ^ {57'd0, eff_len};
              cnt_lo <= '0;
              cnt_hi <= '0;
              fill <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_blake2b_hash_engine.sv
// tb_blake2b_hash_engine: self-checking bench for the byte-stream BLAKE2b engine.
// Depends on b2b_pkg, the channel interfaces in b2b_if.sv and blake2b_hash_engine.
`timescale 1ns / 1ps
module tb_blake2b_hash_engine;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainWait  = 300;
  localparam int unsigned BlockBytes = 128;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic        last_word;
  } digest_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  b2b_byte_if   in_if();
  b2b_digest_if out_if();
  b2b_cfg_if    cfg_if();

  blake2b_hash_engine u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // message schedule and G column/diagonal indices
  int unsigned msg_sched [0:11][0:15] = '{
    '{ 0, 1, 2, 3, 4, 5, 6, 7, 8, 9,10,11,12,13,14,15},
    '{14,10, 4, 8, 9,15,13, 6, 1,12, 0, 2,11, 7, 5, 3},
    '{11, 8,12, 0, 5, 2,15,13,10,14, 3, 6, 7, 1, 9, 4},
    '{ 7, 9, 3, 1,13,12,11,14, 2, 6, 5,10, 4, 0,15, 8},
    '{ 9, 0, 5, 7, 2, 4,10,15,14, 1,11,12, 6, 8, 3,13},
    '{ 2,12, 6,10, 0,11, 8, 3, 4,13, 7, 5,15,14, 1, 9},
    '{12, 5, 1,15,14,13, 4,10, 0, 7, 6, 3, 9, 2, 8,11},
    '{13,11, 7,14,12, 1, 3, 9, 5, 0,15, 4, 8, 6, 2,10},
    '{ 6,15,14, 9,11, 3, 0, 8,12, 2,13, 7, 1, 4,10, 5},
    '{10, 2, 8, 4, 7, 6, 1, 5,15,11, 9,14, 3,12,13, 0},
    '{ 0, 1, 2, 3, 4, 5, 6, 7, 8, 9,10,11,12,13,14,15},
    '{14,10, 4, 8, 9,15,13, 6, 1,12, 0, 2,11, 7, 5, 3}
  };
  int unsigned g_lanes [0:7][0:3] = '{
    '{0, 4,  8, 12}, '{1, 5,  9, 13}, '{2, 6, 10, 14}, '{3, 7, 11, 15},
    '{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7,  8, 13}, '{3, 4,  9, 14}
  };
  logic [63:0] init_vec [0:7] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  // hash state mirror
  logic [63:0]  chain [0:7];
  logic [127:0] byte_total;
  logic [7:0]   blk_bytes [0:BlockBytes-1];
  int unsigned  blk_fill;
  int unsigned  out_len;

  digest_item_t digest_q [$];
  int unsigned  error_count = 0;
  int unsigned  accepted_items = 0;
  int unsigned  cycle_count = 0;

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic new_message();
    for (int i = 0; i < 8; i++) chain[i] = init_vec[i];
    chain[0] ^= 64'h01010000 | 64'(out_len);
    byte_total = '0;
    blk_fill = 0;
  endtask

  // 12-round compression; bytes at or past blk_fill read as zero
  task automatic compress_block(input bit final_blk);
    logic [63:0] v [0:15];
    logic [63:0] m [0:15];
    int unsigned a, b, c, d;
    for (int w = 0; w < 16; w++) begin
      m[w] = '0;
      for (int k = 0; k < 8; k++)
        if (w * 8 + k < blk_fill) m[w][8*k +: 8] = blk_bytes[w*8+k];
    end
    for (int i = 0; i < 8; i++) begin
      v[i] = chain[i];
      v[i+8] = init_vec[i];
    end
    v[12] ^= byte_total[63:0];
    v[13] ^= byte_total[127:64];
    if (final_blk) v[14] = ~v[14];
    for (int r = 0; r < 12; r++) begin
      for (int g = 0; g < 8; g++) begin
        a = g_lanes[g][0]; b = g_lanes[g][1]; c = g_lanes[g][2]; d = g_lanes[g][3];
        v[a] = v[a] + v[b] + m[msg_sched[r][2*g]];
        v[d] = rotr(v[d] ^ v[a], 32);
        v[c] = v[c] + v[d];
        v[b] = rotr(v[b] ^ v[c], 24);
        v[a] = v[a] + v[b] + m[msg_sched[r][2*g+1]];
        v[d] = rotr(v[d] ^ v[a], 16);
        v[c] = v[c] + v[d];
        v[b] = rotr(v[b] ^ v[c], 63);
      end
    end
    for (int i = 0; i < 8; i++) chain[i] ^= v[i] ^ v[i+8];
  endtask

  // advance the mirror by one accepted item, queue the digest words it causes
  task automatic hash_byte_item(input byte_item_t it);
    int unsigned nwords, rem;
    digest_item_t dw;
    if (it.has_byte) begin
      if (blk_fill >= BlockBytes) begin
        byte_total += 128'(BlockBytes);
        compress_block(1'b0);
        blk_fill = 0;
      end
      blk_bytes[blk_fill] = it.data_byte;
      blk_fill++;
    end
    if (it.last) begin
      byte_total += 128'(blk_fill);
      compress_block(1'b1);
      nwords = (out_len + 7) / 8;
      for (int k = 0; k < nwords; k++) begin
        rem = out_len - 8 * k;
        dw.digest_word = chain[k];
        if (rem < 8) dw.digest_word &= (64'd1 << (8 * rem)) - 64'd1;
        dw.last_word = (k + 1 == nwords);
        digest_q.push_back(dw);
      end
      new_message();
    end
  endtask

  task automatic set_length(input logic [6:0] val);
    if (val == 0) out_len = 1;
    else if (val > b2b_pkg::MaxDigest) out_len = b2b_pkg::MaxDigest;
    else out_len = val;
    new_message();
  endtask

  initial begin
    out_len = b2b_pkg::DefDigestLen;
    new_message();
  end

  // input side acceptance, register writes and output checking
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) set_length(cfg_if.digest_length);
      if (out_if.valid && out_if.ready) begin
        if (digest_q.size() == 0) begin
          $error("digest word with none expected: %h", out_if.digest_word);
          error_count++;
        end else begin
          if (out_if.digest_word !== digest_q[0].digest_word) begin
            $error("digest_word expected %h actual %h",
                   digest_q[0].digest_word, out_if.digest_word);
            error_count++;
          end
          if (out_if.last_word !== digest_q[0].last_word) begin
            $error("last_word expected %b actual %b",
                   digest_q[0].last_word, out_if.last_word);
            error_count++;
          end
          void'(digest_q.pop_front());
        end
      end
      if (in_if.valid && in_if.ready) begin
        hash_byte_item('{in_if.data_byte, in_if.has_byte, in_if.last});
        accepted_items++;
      end
    end
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_blake2b_hash_engine: done, errors");
      $finish;
    end
  end

  bit no_idle = 1'b0;

  function automatic int unsigned gap_len();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls plus one long hold-off once the stream is going
  bit          held = 1'b0;
  int unsigned rx_wait;
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && accepted_items >= 40) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        for (int i = 1; i < 500; i++) @(negedge clk);
      end else begin
        rx_wait = gap_len();
        if (rx_wait == 0) begin
          out_if.ready <= 1'b1;
        end else begin
          out_if.ready <= 1'b0;
          for (int i = 1; i < rx_wait; i++) @(negedge clk);
        end
      end
    end
  end

  task automatic send_item(input byte_item_t it);
    int unsigned g;
    g = gap_len();
    for (int i = 0; i < g; i++) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid     <= 1'b1;
    in_if.data_byte <= it.data_byte;
    in_if.has_byte  <= it.has_byte;
    in_if.last      <= it.last;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_length(input logic [6:0] val);
    @(negedge clk);
    cfg_if.valid         <= 1'b1;
    cfg_if.digest_length <= val;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // one message of n bytes; sometimes closed by a separate byte-less last item
  int unsigned rand_items = 0;
  task automatic send_message(input int unsigned n);
    bit split_end;
    split_end = (n == 0) || ($urandom_range(0, 3) == 0);
    no_idle = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) send_item('{8'($urandom), 1'b0, 1'b0});
      send_item('{8'($urandom_range(0, 255)), 1'b1, (i == n - 1) && !split_end});
      rand_items++;
    end
    if (split_end) begin
      send_item('{8'($urandom), 1'b0, 1'b1});
      rand_items++;
    end
  endtask

  // directed rows: idle item, empty message, byte extremes, split ending, "abc"
  byte_item_t directed [] = '{
    '{8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b1},
    '{8'h00, 1'b1, 1'b1},
    '{8'hff, 1'b1, 1'b1},
    '{8'h55, 1'b1, 1'b0},
    '{8'haa, 1'b1, 1'b0},
    '{8'hff, 1'b0, 1'b0},
    '{8'hff, 1'b0, 1'b1},
    '{8'h61, 1'b1, 1'b0},
    '{8'h62, 1'b1, 1'b0},
    '{8'h63, 1'b1, 1'b1},
    '{8'h80, 1'b1, 1'b0},
    '{8'h7f, 1'b1, 1'b1}
  };

  logic [6:0] phase_len [0:6];
  int unsigned long_sizes [0:1] = '{128, 129};
  int unsigned long_done = 0;
  int unsigned phase_quota;

  initial begin
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.has_byte = 1'b0;
    in_if.last = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.digest_length = '0;
    phase_len = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd32,
                  7'($urandom_range(0, 127)), 7'($urandom_range(1, 64))};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset length
    foreach (directed[i]) send_item(directed[i]);
    wait_idle();

    // random phases, one per length setting
    for (int p = 0; p < 7; p++) begin
      write_length(phase_len[p]);
      phase_quota = rand_items + 25;
      while (rand_items < phase_quota) begin
        if (long_done < 2 && p >= 1 && $urandom_range(0, 3) == 0) begin
          send_message(long_sizes[long_done]);
          long_done++;
        end else begin
          send_message($urandom_range(0, 12));
        end
      end
      wait_idle();
    end

    if (error_count == 0)
      $display("tb_blake2b_hash_engine: done, clean");
    else
      $display("tb_blake2b_hash_engine: done, errors");
    $finish;
  end

endmodule
